@@ rtl/core/rbp_pkg.sv @@
package rbp_pkg;

	localparam int W = 48;
	localparam int NUM_CFG = 7;
	localparam int NUM_IN = 12;
	localparam int NUM_SLOT = 7;
	localparam int RF_DEPTH = 64;
	localparam int RF_AW = $clog2(RF_DEPTH);
	localparam int PROG_LEN = 143;
	localparam int PC_W = $clog2(PROG_LEN);

	localparam logic signed [W-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [W-1:0] Q_MIN = 48'sh8000_0000_0000;
	localparam logic signed [W-1:0] Q_ONE = 48'sd16777216;
	localparam logic signed [W-1:0] Q_TWO = 48'sd33554432;

	// configuration register indexes
	localparam logic [2:0] CFG_HS = 3'd0;
	localparam logic [2:0] CFG_HK = 3'd1;
	localparam logic [2:0] CFG_IC2 = 3'd2;
	localparam logic [2:0] CFG_ISX = 3'd3;
	localparam logic [2:0] CFG_ISY = 3'd4;
	localparam logic [2:0] CFG_ISZ = 3'd5;
	localparam logic [2:0] CFG_LG = 3'd6;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_DIVZ,
		OP_SQRT,
		OP_MAX,
		OP_CLAMP,
		OP_AVG,
		OP_OUT,
		OP_END
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_WAIT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] dst;
		logic [6:0] a;
		logic [6:0] b;
		logic [1:0] ax;
	} uop_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic                done;
		logic signed [W-1:0] res;
	} alu_rsp_t;

	// operand addresses: inputs, config, constants, then register file (bit 6 set)
	localparam logic [6:0] AP0 = 7'd0;
	localparam logic [6:0] AV0 = 7'd3;
	localparam logic [6:0] AE0 = 7'd6;
	localparam logic [6:0] AB0 = 7'd9;
	localparam logic [6:0] A_CFG = 7'd12;
	localparam logic [6:0] A_HS = 7'd12;
	localparam logic [6:0] A_HK = 7'd13;
	localparam logic [6:0] A_IC2 = 7'd14;
	localparam logic [6:0] A_IS0 = 7'd15;
	localparam logic [6:0] A_LG = 7'd18;
	localparam logic [6:0] A_ONE = 7'd19;
	localparam logic [6:0] A_TWO = 7'd20;
	localparam logic [6:0] A_ZERO = 7'd21;

	localparam logic [6:0] T_A = 7'd64;
	localparam logic [6:0] T_B = 7'd65;
	localparam logic [6:0] T_C = 7'd66;
	localparam logic [6:0] T_T = 7'd67;
	localparam logic [6:0] T_G0 = 7'd68;
	localparam logic [6:0] T_U = 7'd69;
	localparam logic [6:0] T_NP = 7'd72;
	localparam logic [6:0] T_BM2 = 7'd75;
	localparam logic [6:0] T_K = 7'd76;
	localparam logic [6:0] T_E = 7'd77;
	localparam logic [6:0] T_UM = 7'd80;
	localparam logic [6:0] T_GM = 7'd83;
	localparam logic [6:0] T_R = 7'd84;
	localparam logic [6:0] T_BB = 7'd85;
	localparam logic [6:0] T_B2 = 7'd88;
	localparam logic [6:0] T_U1 = 7'd89;
	localparam logic [6:0] T_S = 7'd92;
	localparam logic [6:0] T_UN = 7'd93;
	localparam logic [6:0] T_U2 = 7'd96;
	localparam logic [6:0] T_GN = 7'd97;
	localparam logic [6:0] T_VN = 7'd98;
	localparam logic [6:0] T_BND = 7'd101;

	localparam logic [6:0] O1 = 7'd1;
	localparam logic [6:0] O2 = 7'd2;

	function automatic uop_t u(input op_t op, input logic [6:0] d, input logic [6:0] a,
			input logic [6:0] b);
		uop_t r;
		r.op = op;
		r.dst = d;
		r.a = a;
		r.b = b;
		r.ax = 2'd0;
		return r;
	endfunction

	function automatic uop_t ux(input op_t op, input logic [6:0] d, input logic [6:0] a,
			input logic [6:0] b, input logic [1:0] ax);
		uop_t r;
		r = u(op, d, a, b);
		r.ax = ax;
		return r;
	endfunction

	localparam uop_t PROG [PROG_LEN] = '{
		// gamma at start
		u(OP_MUL, T_A, AV0, AV0), u(OP_MUL, T_B, AV0+O1, AV0+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, AV0+O2, AV0+O2), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_A, T_A, A_IC2), u(OP_SUB, T_A, A_ONE, T_A), u(OP_CLAMP, T_A, T_A, T_A),
		u(OP_SQRT, T_A, T_A, T_A), u(OP_DIV, T_G0, A_ONE, T_A),
		// half drift, four-velocity
		u(OP_MUL, T_B, A_HS, AV0), u(OP_ADD, T_NP, AP0, T_B), u(OP_MUL, T_U, AV0, T_G0),
		u(OP_MUL, T_B, A_HS, AV0+O1), u(OP_ADD, T_NP+O1, AP0+O1, T_B),
		u(OP_MUL, T_U+O1, AV0+O1, T_G0),
		u(OP_MUL, T_B, A_HS, AV0+O2), u(OP_ADD, T_NP+O2, AP0+O2, T_B),
		u(OP_MUL, T_U+O2, AV0+O2, T_G0),
		// B.B
		u(OP_MUL, T_A, AB0, AB0), u(OP_MUL, T_B, AB0+O1, AB0+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, AB0+O2, AB0+O2), u(OP_ADD, T_BM2, T_A, T_B),
		// E.B and clean
		u(OP_MUL, T_A, AE0, AB0), u(OP_MUL, T_B, AE0+O1, AB0+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, AE0+O2, AB0+O2), u(OP_ADD, T_A, T_A, T_B),
		u(OP_DIVZ, T_K, T_A, T_BM2),
		u(OP_MUL, T_B, T_K, AB0), u(OP_SUB, T_E, AE0, T_B),
		u(OP_MUL, T_B, T_K, AB0+O1), u(OP_SUB, T_E+O1, AE0+O1, T_B),
		u(OP_MUL, T_B, T_K, AB0+O2), u(OP_SUB, T_E+O2, AE0+O2, T_B),
		// first kick
		u(OP_MUL, T_B, A_HK, T_E), u(OP_ADD, T_UM, T_U, T_B),
		u(OP_MUL, T_B, A_HK, T_E+O1), u(OP_ADD, T_UM+O1, T_U+O1, T_B),
		u(OP_MUL, T_B, A_HK, T_E+O2), u(OP_ADD, T_UM+O2, T_U+O2, T_B),
		u(OP_MUL, T_A, T_UM, T_UM), u(OP_MUL, T_B, T_UM+O1, T_UM+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, T_UM+O2, T_UM+O2), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_A, T_A, A_IC2), u(OP_ADD, T_A, A_ONE, T_A), u(OP_SQRT, T_GM, T_A, T_A),
		u(OP_DIV, T_R, A_HK, T_GM),
		u(OP_MUL, T_BB, T_R, AB0), u(OP_MUL, T_BB+O1, T_R, AB0+O1),
		u(OP_MUL, T_BB+O2, T_R, AB0+O2),
		u(OP_MUL, T_A, T_BB, T_BB), u(OP_MUL, T_B, T_BB+O1, T_BB+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, T_BB+O2, T_BB+O2), u(OP_ADD, T_B2, T_A, T_B),
		// u1 = um + um x b
		u(OP_MUL, T_A, T_UM+O1, T_BB+O2), u(OP_MUL, T_B, T_UM+O2, T_BB+O1),
		u(OP_SUB, T_A, T_A, T_B), u(OP_ADD, T_U1, T_UM, T_A),
		u(OP_MUL, T_A, T_UM+O2, T_BB), u(OP_MUL, T_B, T_UM, T_BB+O2),
		u(OP_SUB, T_A, T_A, T_B), u(OP_ADD, T_U1+O1, T_UM+O1, T_A),
		u(OP_MUL, T_A, T_UM, T_BB+O1), u(OP_MUL, T_B, T_UM+O1, T_BB),
		u(OP_SUB, T_A, T_A, T_B), u(OP_ADD, T_U1+O2, T_UM+O2, T_A),
		u(OP_ADD, T_A, A_ONE, T_B2), u(OP_DIV, T_S, A_TWO, T_A),
		// rotate and second kick
		u(OP_MUL, T_A, T_U1+O1, T_BB+O2), u(OP_MUL, T_B, T_U1+O2, T_BB+O1),
		u(OP_SUB, T_A, T_A, T_B), u(OP_MUL, T_A, T_S, T_A), u(OP_ADD, T_A, T_UM, T_A),
		u(OP_MUL, T_B, A_HK, T_E), u(OP_ADD, T_UN, T_A, T_B),
		u(OP_MUL, T_A, T_U1+O2, T_BB), u(OP_MUL, T_B, T_U1, T_BB+O2),
		u(OP_SUB, T_A, T_A, T_B), u(OP_MUL, T_A, T_S, T_A), u(OP_ADD, T_A, T_UM+O1, T_A),
		u(OP_MUL, T_B, A_HK, T_E+O1), u(OP_ADD, T_UN+O1, T_A, T_B),
		u(OP_MUL, T_A, T_U1, T_BB+O1), u(OP_MUL, T_B, T_U1+O1, T_BB),
		u(OP_SUB, T_A, T_A, T_B), u(OP_MUL, T_A, T_S, T_A), u(OP_ADD, T_A, T_UM+O2, T_A),
		u(OP_MUL, T_B, A_HK, T_E+O2), u(OP_ADD, T_UN+O2, T_A, T_B),
		u(OP_MUL, T_A, T_UN, T_UN), u(OP_MUL, T_B, T_UN+O1, T_UN+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, T_UN+O2, T_UN+O2), u(OP_ADD, T_U2, T_A, T_B),
		u(OP_MUL, T_A, T_U2, A_IC2), u(OP_ADD, T_A, A_ONE, T_A), u(OP_SQRT, T_GN, T_A, T_A),
		// new velocity, second drift
		u(OP_DIV, T_VN, T_UN, T_GN), u(OP_MUL, T_B, A_HS, T_VN), u(OP_ADD, T_A, T_NP, T_B),
		u(OP_OUT, 7'd0, T_A, T_A), u(OP_OUT, 7'd3, T_VN, T_VN),
		u(OP_DIV, T_VN+O1, T_UN+O1, T_GN), u(OP_MUL, T_B, A_HS, T_VN+O1),
		u(OP_ADD, T_A, T_NP+O1, T_B), u(OP_OUT, 7'd1, T_A, T_A), u(OP_OUT, 7'd4, T_VN+O1, T_VN+O1),
		u(OP_DIV, T_VN+O2, T_UN+O2, T_GN), u(OP_MUL, T_B, A_HS, T_VN+O2),
		u(OP_ADD, T_A, T_NP+O2, T_B), u(OP_OUT, 7'd2, T_A, T_A), u(OP_OUT, 7'd5, T_VN+O2, T_VN+O2),
		// crossing limit
		u(OP_ADD, T_BND, A_ZERO, A_ZERO),
		u(OP_AVG, T_A, T_VN, AV0), u(OP_MUL, T_A, T_A, A_IS0),
		ux(OP_MAX, T_BND, T_BND, T_A, 2'd1),
		u(OP_AVG, T_A, T_VN+O1, AV0+O1), u(OP_MUL, T_A, T_A, A_IS0+O1),
		ux(OP_MAX, T_BND, T_BND, T_A, 2'd2),
		u(OP_AVG, T_A, T_VN+O2, AV0+O2), u(OP_MUL, T_A, T_A, A_IS0+O2),
		ux(OP_MAX, T_BND, T_BND, T_A, 2'd3),
		// Larmor limit
		u(OP_MUL, T_A, T_VN, AB0), u(OP_MUL, T_B, T_VN+O1, AB0+O1), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_B, T_VN+O2, AB0+O2), u(OP_ADD, T_A, T_A, T_B),
		u(OP_MUL, T_T, T_A, T_A), u(OP_MUL, T_B, T_GN, T_GN), u(OP_DIV, T_C, T_U2, T_B),
		u(OP_DIVZ, T_T, T_T, T_C), u(OP_SUB, T_A, T_BM2, T_T), u(OP_SQRT, T_A, T_A, T_A),
		u(OP_MUL, T_A, T_A, A_LG), u(OP_DIV, T_A, T_A, T_GN),
		u(OP_MAX, T_BND, T_BND, T_A),
		u(OP_OUT, 7'd6, T_BND, T_BND), u(OP_END, T_A, T_A, T_A)
	};

	function automatic logic signed [W-1:0] sat49(input logic signed [W:0] v);
		if (v[W] != v[W-1]) return v[W] ? Q_MIN : Q_MAX;
		return v[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic signed [W-1:0] signq(input logic neg, input logic [50:0] m);
		logic [50:0] lim;
		logic [50:0] c;
		lim = neg ? 51'h0_8000_0000_0000 : 51'h0_7FFF_FFFF_FFFF;
		c = (m > lim) ? lim : m;
		return neg ? -c[W-1:0] : c[W-1:0];
	endfunction

endpackage

@@ rtl/core/rbp_rf.sv @@
module rbp_rf (
	input  logic                                clk,
	input  logic                                we,
	input  logic [rbp_pkg::RF_AW-1:0]           waddr,
	input  logic signed [rbp_pkg::W-1:0]        wdata,
	input  logic [rbp_pkg::RF_AW-1:0]           raddr_a,
	input  logic [rbp_pkg::RF_AW-1:0]           raddr_b,
	output logic signed [rbp_pkg::W-1:0]        rdata_a,
	output logic signed [rbp_pkg::W-1:0]        rdata_b
);

	logic signed [rbp_pkg::W-1:0] mem [rbp_pkg::RF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/core/rbp_alu.sv @@
module rbp_alu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rbp_pkg::alu_req_t              req,
	input  logic signed [rbp_pkg::W-1:0]   a,
	input  logic signed [rbp_pkg::W-1:0]   b,
	output rbp_pkg::alu_rsp_t              rsp
);

	logic        busy_q, done_q, neg_q, big_q;
	rbp_pkg::op_t op_q;
	logic [6:0]  cnt_q;
	logic [47:0] ma_q, mb_q, prod_q;
	logic [71:0] num_q, quo_q;
	logic [48:0] rem_q;
	logic [50:0] acc_q;
	logic signed [47:0] res_q;

	logic [47:0] ma_in, mb_in;
	logic        is_div, long_op, last;
	logic signed [47:0] fast_res, fin_res;
	logic [23:0] mx, my;
	logic [47:0] mul_p;
	logic [48:0] drem, dsub;
	logic        dge;
	logic [39:0] srem, strial, ssub;
	logic        sge;
	logic [48:0] avg_sum;
	logic [47:0] avg_half;

	assign ma_in = rbp_pkg::mag(a);
	assign mb_in = rbp_pkg::mag(b);
	assign is_div = (req.op == rbp_pkg::OP_DIV) || (req.op == rbp_pkg::OP_DIVZ);
	assign long_op = (req.op == rbp_pkg::OP_MUL)
		|| (is_div && ma_in != '0 && mb_in != '0)
		|| (req.op == rbp_pkg::OP_SQRT && a > 0);

	always_comb begin
		last = 1'b0;
		if (busy_q) begin
			case (op_q)
				rbp_pkg::OP_MUL:  last = (cnt_q == 7'd4);
				rbp_pkg::OP_DIV,
				rbp_pkg::OP_DIVZ: last = (cnt_q == 7'd72);
				rbp_pkg::OP_SQRT: last = (cnt_q == 7'd36);
				default:          last = 1'b0;
			endcase
		end
	end

	assign avg_sum = {1'b0, ma_in} + {1'b0, mb_in};
	assign avg_half = avg_sum[48:1];

	always_comb begin
		case (req.op)
			rbp_pkg::OP_ADD:   fast_res = rbp_pkg::sat49({a[47], a} + {b[47], b});
			rbp_pkg::OP_SUB:   fast_res = rbp_pkg::sat49({a[47], a} - {b[47], b});
			rbp_pkg::OP_MAX:   fast_res = (b > a) ? b : a;
			rbp_pkg::OP_CLAMP: fast_res = (a < 48'sd1) ? 48'sd1 : a;
			rbp_pkg::OP_AVG:   fast_res = (avg_half > 48'h7FFF_FFFF_FFFF) ? rbp_pkg::Q_MAX
				: $signed(avg_half);
			rbp_pkg::OP_DIV:   fast_res = (ma_in == '0) ? '0 : (a[47] ? rbp_pkg::Q_MIN
				: rbp_pkg::Q_MAX);
			default:           fast_res = '0;
		endcase
	end

	// multiply in four 24x24 partial products
	assign mx = cnt_q[1] ? ma_q[23:0] : ma_q[47:24];
	assign my = cnt_q[0] ? mb_q[23:0] : mb_q[47:24];
	assign mul_p = mx * my;

	// restoring divide, one quotient bit per cycle
	assign drem = {rem_q[47:0], num_q[71]};
	assign dge = drem >= {1'b0, mb_q};
	assign dsub = drem - {1'b0, mb_q};

	// square root, two radicand bits per cycle
	assign srem = {rem_q[37:0], num_q[71:70]};
	assign strial = {2'b00, quo_q[35:0], 2'b01};
	assign sge = srem >= strial;
	assign ssub = srem - strial;

	always_comb begin
		case (op_q)
			rbp_pkg::OP_MUL: fin_res = rbp_pkg::signq(neg_q, big_q ? 51'h0_8000_0000_0000
				: acc_q + ({3'b000, prod_q} >> 24) + {50'd0, prod_q[23]});
			rbp_pkg::OP_DIV,
			rbp_pkg::OP_DIVZ: fin_res = rbp_pkg::signq(neg_q, (|quo_q[71:47])
				? 51'h0_8000_0000_0000 : {4'b0000, quo_q[46:0]});
			rbp_pkg::OP_SQRT: fin_res = {12'd0, quo_q[35:0]};
			default:          fin_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= rbp_pkg::OP_ADD;
		end else begin
			done_q <= (req.start && !long_op) || last;
			if (req.start) begin
				busy_q <= long_op;
				cnt_q <= '0;
				op_q <= req.op;
			end else if (busy_q) begin
				busy_q <= !last;
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q <= ma_in;
			mb_q <= mb_in;
			neg_q <= a[47] ^ b[47];
			num_q <= (req.op == rbp_pkg::OP_SQRT) ? {a, 24'd0} : {ma_in, 24'd0};
			rem_q <= '0;
			quo_q <= '0;
			res_q <= fast_res;
		end else if (busy_q) begin
			case (op_q)
				rbp_pkg::OP_MUL: begin
					prod_q <= mul_p;
					if (cnt_q == 7'd1) begin
						acc_q <= {prod_q[26:0], 24'd0};
						big_q <= |prod_q[47:23];
					end else if (cnt_q == 7'd2 || cnt_q == 7'd3) begin
						acc_q <= acc_q + {3'b000, prod_q};
					end
				end
				rbp_pkg::OP_DIV,
				rbp_pkg::OP_DIVZ: begin
					if (!last) begin
						num_q <= {num_q[70:0], 1'b0};
						rem_q <= dge ? dsub : drem;
						quo_q <= {quo_q[70:0], dge};
					end
				end
				rbp_pkg::OP_SQRT: begin
					if (!last) begin
						num_q <= {num_q[69:0], 2'b00};
						rem_q <= {11'd0, sge ? ssub[37:0] : srem[37:0]};
						quo_q <= {quo_q[70:0], sge};
					end
				end
				default: begin
				end
			endcase
			if (last) begin
				res_q <= fin_res;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule

@@ rtl/core/relativistic_boris_particle_push_core.sv @@
// A divide meeting a zero operand, or a root meeting a non-positive one, finishes early. An
// input beat is taken only when the sequencer is idle, so a new particle is not accepted
// until the last result has been loaded into the output register.
// A 143-step microprogram runs on one shared ALU: 10 restoring divides (one quotient bit per
// cycle), 66 multiplies and 4 square roots.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, config at reset values,
// internal running maximum at one LSB (the running_bound output register is not reset).
module relativistic_boris_particle_push_core #(
	parameter int SPACE_DIMS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [46:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [47:0] pos_x,
	input  logic signed [47:0] pos_y,
	input  logic signed [47:0] pos_z,
	input  logic signed [47:0] vel_x,
	input  logic signed [47:0] vel_y,
	input  logic signed [47:0] vel_z,
	input  logic signed [47:0] elec_x,
	input  logic signed [47:0] elec_y,
	input  logic signed [47:0] elec_z,
	input  logic signed [47:0] mag_x,
	input  logic signed [47:0] mag_y,
	input  logic signed [47:0] mag_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] new_pos_x,
	output logic signed [47:0] new_pos_y,
	output logic signed [47:0] new_pos_z,
	output logic signed [47:0] new_vel_x,
	output logic signed [47:0] new_vel_y,
	output logic signed [47:0] new_vel_z,
	output logic [46:0]        step_bound,
	output logic [46:0]        running_bound
);

	rbp_pkg::state_t state_q, state_d;
	logic [rbp_pkg::PC_W-1:0] pc_q;
	rbp_pkg::uop_t uop;
	logic [46:0] cfg_q [rbp_pkg::NUM_CFG];
	logic signed [47:0] in_q [rbp_pkg::NUM_IN];
	logic signed [47:0] stage_q [rbp_pkg::NUM_SLOT];
	logic signed [47:0] out_q [6];
	logic [46:0] bound_q, mx_q, run_q;
	logic out_valid_q;

	logic pc_inc, stage_we, fin_load, mem_we, skip;
	rbp_pkg::alu_req_t alu_req;
	rbp_pkg::alu_rsp_t alu_rsp;
	logic signed [47:0] rd_a, rd_b, spec_a, spec_b, opa, opb;
	logic [46:0] fin_bound, mx_next;

	assign uop = rbp_pkg::PROG[pc_q];
	assign skip = (uop.ax != 2'd0) && (int'(uop.ax) > SPACE_DIMS);

	function automatic logic signed [47:0] spec_sel(input logic [6:0] ad);
		logic signed [47:0] v;
		v = '0;
		for (int i = 0; i < rbp_pkg::NUM_IN; i++) begin
			if (ad == 7'(i)) v = in_q[i];
		end
		for (int i = 0; i < rbp_pkg::NUM_CFG; i++) begin
			if (ad == rbp_pkg::A_CFG + 7'(i)) v = {1'b0, cfg_q[i]};
		end
		if (ad == rbp_pkg::A_ONE) v = rbp_pkg::Q_ONE;
		if (ad == rbp_pkg::A_TWO) v = rbp_pkg::Q_TWO;
		return v;
	endfunction

	assign spec_a = spec_sel(uop.a);
	assign spec_b = spec_sel(uop.b);
	assign opa = uop.a[6] ? rd_a : spec_a;
	assign opb = uop.b[6] ? rd_b : spec_b;

	rbp_rf u_rf (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (uop.dst[rbp_pkg::RF_AW-1:0]),
		.wdata   (alu_rsp.res),
		.raddr_a (uop.a[rbp_pkg::RF_AW-1:0]),
		.raddr_b (uop.b[rbp_pkg::RF_AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	rbp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opa),
		.b      (opb),
		.rsp    (alu_rsp)
	);

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		pc_inc = 1'b0;
		stage_we = 1'b0;
		fin_load = 1'b0;
		mem_we = 1'b0;
		alu_req.start = 1'b0;
		alu_req.op = uop.op;
		case (state_q)
			rbp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = rbp_pkg::ST_READ;
			end
			rbp_pkg::ST_READ: state_d = rbp_pkg::ST_EXEC;
			rbp_pkg::ST_EXEC: begin
				case (uop.op)
					rbp_pkg::OP_OUT: begin
						stage_we = 1'b1;
						pc_inc = 1'b1;
						state_d = rbp_pkg::ST_READ;
					end
					rbp_pkg::OP_END: begin
						if (!out_valid_q || out_ready) begin
							fin_load = 1'b1;
							state_d = rbp_pkg::ST_IDLE;
						end
					end
					default: begin
						if (skip) begin
							pc_inc = 1'b1;
							state_d = rbp_pkg::ST_READ;
						end else begin
							alu_req.start = 1'b1;
							state_d = rbp_pkg::ST_WAIT;
						end
					end
				endcase
			end
			rbp_pkg::ST_WAIT: begin
				if (alu_rsp.done) begin
					mem_we = 1'b1;
					pc_inc = 1'b1;
					state_d = rbp_pkg::ST_READ;
				end
			end
			default: state_d = rbp_pkg::ST_IDLE;
		endcase
	end

	assign fin_bound = stage_q[6][46:0];
	assign mx_next = (fin_bound > mx_q) ? fin_bound : mx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbp_pkg::ST_IDLE;
			pc_q <= '0;
			out_valid_q <= 1'b0;
			mx_q <= 47'd1;
			for (int i = 0; i < rbp_pkg::NUM_CFG; i++) cfg_q[i] <= '0;
			cfg_q[rbp_pkg::CFG_IC2] <= rbp_pkg::Q_ONE[46:0];
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				pc_q <= '0;
			end else if (pc_inc) begin
				pc_q <= pc_q + 1'b1;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
				mx_q <= mx_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_index < 3'(rbp_pkg::NUM_CFG)) begin
				cfg_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q[0] <= pos_x;
			in_q[1] <= pos_y;
			in_q[2] <= pos_z;
			in_q[3] <= vel_x;
			in_q[4] <= vel_y;
			in_q[5] <= vel_z;
			in_q[6] <= elec_x;
			in_q[7] <= elec_y;
			in_q[8] <= elec_z;
			in_q[9] <= mag_x;
			in_q[10] <= mag_y;
			in_q[11] <= mag_z;
		end
		if (stage_we) begin
			stage_q[uop.dst[2:0]] <= opa;
		end
		if (fin_load) begin
			for (int i = 0; i < 6; i++) out_q[i] <= stage_q[i];
			bound_q <= fin_bound;
			run_q <= mx_next;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign new_pos_x = out_q[0];
	assign new_pos_y = out_q[1];
	assign new_pos_z = out_q[2];
	assign new_vel_x = out_q[3];
	assign new_vel_y = out_q[4];
	assign new_vel_z = out_q[5];
	assign step_bound = bound_q;
	assign running_bound = run_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == rbp_pkg::ST_WAIT)
		else $error("alu result outside wait state");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != rbp_pkg::ST_IDLE |-> int'(pc_q) < rbp_pkg::PROG_LEN)
		else $error("program counter out of range");

	a_max_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> mx_q >= $past(mx_q))
		else $error("running bound decreased");

	a_bound_le_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_bound <= running_bound)
		else $error("step bound above running bound");

endmodule

@@ dv/relativistic_boris_particle_push_core_tb.sv @@
`timescale 1ns / 1ps

module relativistic_boris_particle_push_core_tb;

	localparam longint P_MAX = 64'sd140737488355327;
	localparam longint P_MIN = -P_MAX - 1;
	localparam longint P_ONE = 64'sd16777216;
	localparam longint MASK47 = 64'h7FFF_FFFF_FFFF;
	localparam int LAT = 2000;
	localparam int HOLD_LEN = 8000;
	localparam longint LIMIT = 6000000;

	typedef longint vec3_t [3];

	typedef struct {
		logic signed [47:0] p [3];
		logic signed [47:0] v [3];
		logic signed [47:0] e [3];
		logic signed [47:0] b [3];
	} particle_t;

	typedef struct {
		logic signed [47:0] np [3];
		logic signed [47:0] vn [3];
		logic [46:0]        sb;
		logic [46:0]        rb;
	} push_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [46:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [47:0] pin [3];
	logic signed [47:0] vin [3];
	logic signed [47:0] ein [3];
	logic signed [47:0] bfld [3];
	logic out_valid;
	logic out_ready;
	logic signed [47:0] npos [3];
	logic signed [47:0] nvel [3];
	logic [46:0] step_bound;
	logic [46:0] running_bound;

	longint cfg_regs [rbp_pkg::NUM_CFG];
	longint run_max;
	push_t push_q [$];
	int errors;
	longint cycles;
	bit calm;
	bit hold_req;
	bit hold_active;

	relativistic_boris_particle_push_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pin[0]), .pos_y(pin[1]), .pos_z(pin[2]),
		.vel_x(vin[0]), .vel_y(vin[1]), .vel_z(vin[2]),
		.elec_x(ein[0]), .elec_y(ein[1]), .elec_z(ein[2]),
		.mag_x(bfld[0]), .mag_y(bfld[1]), .mag_z(bfld[2]),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_pos_x(npos[0]), .new_pos_y(npos[1]), .new_pos_z(npos[2]),
		.new_vel_x(nvel[0]), .new_vel_y(nvel[1]), .new_vel_z(nvel[2]),
		.step_bound(step_bound), .running_bound(running_bound)
	);

	// fixed-point arithmetic, Q23.24 saturating
	function automatic longint fx_sat(input longint v);
		return v > P_MAX ? P_MAX : (v < P_MIN ? P_MIN : v);
	endfunction

	function automatic longint fx_add(input longint a, input longint b);
		return fx_sat(a + b);
	endfunction

	function automatic longint fx_sub(input longint a, input longint b);
		return fx_sat(a - b);
	endfunction

	function automatic longint unsigned fx_mag(input longint a);
		return a < 0 ? longint'(0) - a : a;
	endfunction

	function automatic longint fx_sign(input bit neg, input longint unsigned m);
		longint unsigned lim;
		lim = neg ? longint'(P_MAX) + 1 : P_MAX;
		if (m > lim) m = lim;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		bit neg;
		longint unsigned ma, mb, ah, al, bh, bl, hh, ll, m;
		neg = (a < 0) != (b < 0);
		ma = fx_mag(a);
		mb = fx_mag(b);
		ah = ma >> 24;
		al = ma & 64'hFFFFFF;
		bh = mb >> 24;
		bl = mb & 64'hFFFFFF;
		hh = ah * bh;
		ll = al * bl;
		if (hh >= (64'd1 << 23))
			m = longint'(P_MAX) + 1;
		else
			m = (hh << 24) + ah * bl + al * bh + (ll >> 24) + ((ll >> 23) & 1);
		return fx_sign(neg, m);
	endfunction

	function automatic longint unsigned scaled_bit(input longint unsigned m, input int i);
		return i >= 24 ? (m >> (i - 24)) & 1 : 0;
	endfunction

	function automatic longint fx_div(input longint a, input longint b);
		bit neg, over;
		longint unsigned ma, mb, rem, q;
		neg = (a < 0) != (b < 0);
		ma = fx_mag(a);
		mb = fx_mag(b);
		rem = 0;
		q = 0;
		over = 0;
		if (ma == 0) return 0;
		if (mb == 0) return a < 0 ? P_MIN : P_MAX;
		for (int i = 71; i >= 0; i--) begin
			rem = (rem << 1) | scaled_bit(ma, i);
			if (rem >= mb) begin
				rem -= mb;
				if (i >= 47) over = 1;
				else q |= 64'd1 << i;
			end
		end
		return fx_sign(neg, over ? longint'(P_MAX) + 1 : q);
	endfunction

	function automatic longint fx_sqrt(input longint x);
		longint unsigned m, rem, root, trial;
		rem = 0;
		root = 0;
		if (x <= 0) return 0;
		m = x;
		for (int p = 35; p >= 0; p--) begin
			rem = (rem << 2) | (scaled_bit(m, 2 * p + 1) << 1) | scaled_bit(m, 2 * p);
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint dot3(input vec3_t a, input vec3_t b);
		return fx_add(fx_add(fx_mul(a[0], b[0]), fx_mul(a[1], b[1])), fx_mul(a[2], b[2]));
	endfunction

	function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
		r[0] = fx_sub(fx_mul(a[1], b[2]), fx_mul(a[2], b[1]));
		r[1] = fx_sub(fx_mul(a[2], b[0]), fx_mul(a[0], b[2]));
		r[2] = fx_sub(fx_mul(a[0], b[1]), fx_mul(a[1], b[0]));
	endfunction

	function automatic push_t boris_push(input particle_t pt);
		push_t res;
		vec3_t pos, vel, ef, bf, uv, um, bb, c1, u1, up, vn, np;
		longint hs, hk, ic2, lg, t, g0, bm2, k, gm, r, b2, s, u2, gn, bnd, term, den, bp2;
		longint avg, lim, oml, vb;
		hs = cfg_regs[rbp_pkg::CFG_HS];
		hk = cfg_regs[rbp_pkg::CFG_HK];
		ic2 = cfg_regs[rbp_pkg::CFG_IC2];
		lg = cfg_regs[rbp_pkg::CFG_LG];
		for (int d = 0; d < 3; d++) begin
			pos[d] = pt.p[d];
			vel[d] = pt.v[d];
			ef[d] = pt.e[d];
			bf[d] = pt.b[d];
		end
		t = fx_sub(P_ONE, fx_mul(dot3(vel, vel), ic2));
		if (t < 1) t = 1;
		g0 = fx_div(P_ONE, fx_sqrt(t));
		for (int d = 0; d < 3; d++) begin
			np[d] = fx_add(pos[d], fx_mul(hs, vel[d]));
			uv[d] = fx_mul(vel[d], g0);
		end
		bm2 = dot3(bf, bf);
		if (bm2 != 0) begin
			k = fx_div(dot3(ef, bf), bm2);
			for (int d = 0; d < 3; d++) ef[d] = fx_sub(ef[d], fx_mul(k, bf[d]));
		end
		for (int d = 0; d < 3; d++) um[d] = fx_add(uv[d], fx_mul(hk, ef[d]));
		gm = fx_sqrt(fx_add(P_ONE, fx_mul(dot3(um, um), ic2)));
		r = fx_div(hk, gm);
		for (int d = 0; d < 3; d++) bb[d] = fx_mul(r, bf[d]);
		b2 = dot3(bb, bb);
		cross3(um, bb, c1);
		for (int d = 0; d < 3; d++) u1[d] = fx_add(um[d], c1[d]);
		s = fx_div(2 * P_ONE, fx_add(P_ONE, b2));
		cross3(u1, bb, c1);
		for (int d = 0; d < 3; d++) up[d] = fx_add(um[d], fx_mul(s, c1[d]));
		for (int d = 0; d < 3; d++) uv[d] = fx_add(up[d], fx_mul(hk, ef[d]));
		u2 = dot3(uv, uv);
		gn = fx_sqrt(fx_add(P_ONE, fx_mul(u2, ic2)));
		for (int d = 0; d < 3; d++) begin
			vn[d] = fx_div(uv[d], gn);
			np[d] = fx_add(np[d], fx_mul(hs, vn[d]));
		end
		bnd = 0;
		for (int d = 0; d < 3 && d < 3; d++) begin
			avg = fx_sat((fx_mag(vn[d]) + fx_mag(vel[d])) / 2);
			lim = fx_mul(avg, cfg_regs[rbp_pkg::CFG_ISX + d]);
			if (lim > bnd) bnd = lim;
		end
		vb = dot3(vn, bf);
		term = fx_mul(vb, vb);
		den = fx_div(u2, fx_mul(gn, gn));
		term = den != 0 ? fx_div(term, den) : 0;
		bp2 = fx_sub(bm2, term);
		if (bp2 < 0) bp2 = 0;
		oml = fx_div(fx_mul(fx_sqrt(bp2), lg), gn);
		if (oml > bnd) bnd = oml;
		if (bnd < 0) bnd = 0;
		if (bnd > run_max) run_max = bnd;
		for (int d = 0; d < 3; d++) begin
			res.np[d] = np[d][47:0];
			res.vn[d] = vn[d][47:0];
		end
		res.sb = bnd[46:0];
		res.rb = run_max[46:0];
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else if (hold_active) begin
			out_ready <= 0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 29);
		end
	end

	initial begin
		hold_active = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_active = 1;
				repeat (HOLD_LEN) @(posedge clk);
				hold_active = 0;
				hold_req = 0;
			end
		end
	end

	function automatic void report(input string what, input longint want, input longint got);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %h actual %h", what, want, got);
	endfunction

	always @(posedge clk) begin
		push_t w;
		if (arst_n && out_valid && out_ready) begin
			if (push_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("mismatch: result beat with nothing expected");
			end else begin
				w = push_q.pop_front();
				for (int d = 0; d < 3; d++) begin
					if (npos[d] !== w.np[d]) report($sformatf("new_pos[%0d]", d), w.np[d], npos[d]);
					if (nvel[d] !== w.vn[d]) report($sformatf("new_vel[%0d]", d), w.vn[d], nvel[d]);
				end
				if (step_bound !== w.sb) report("step_bound", w.sb, step_bound);
				if (running_bound !== w.rb) report("running_bound", w.rb, running_bound);
			end
		end
	end

	task automatic write_config(input longint vals [rbp_pkg::NUM_CFG]);
		for (int i = 0; i <= rbp_pkg::NUM_CFG; i++) begin
			cfg_valid <= 1;
			cfg_index <= i[2:0];
			cfg_data <= (i < rbp_pkg::NUM_CFG) ? vals[i][46:0] : 47'({$urandom, $urandom});
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (i < rbp_pkg::NUM_CFG) cfg_regs[i] = vals[i] & MASK47;
		end
		cfg_valid <= 0;
	endtask

	task automatic send_particle(input particle_t pt);
		int gap;
		gap = (!calm && $urandom_range(99) < 29) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		for (int d = 0; d < 3; d++) begin
			pin[d] <= pt.p[d];
			vin[d] <= pt.v[d];
			ein[d] <= pt.e[d];
			bfld[d] <= pt.b[d];
		end
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		push_q.push_back(boris_push(pt));
	endtask

	task automatic drain;
		in_valid <= 0;
		while (push_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic signed [47:0] rand_q(input int mode);
		logic signed [47:0] x;
		x = 48'({$urandom, $urandom});
		case (mode)
			0: return x;
			1: return 48'(x >>> 22);
			2: return 48'(x >>> 30);
			default: return $urandom_range(1) ? P_MAX[47:0] : P_MIN[47:0];
		endcase
	endfunction

	function automatic particle_t rand_particle(input bit wild);
		particle_t pt;
		int m;
		for (int d = 0; d < 3; d++) begin
			m = wild ? $urandom_range(3) : 1;
			pt.p[d] = rand_q(m);
			pt.v[d] = wild ? rand_q($urandom_range(3)) : rand_q(2);
			pt.e[d] = rand_q(wild ? $urandom_range(3) : 1);
			pt.b[d] = rand_q(wild ? $urandom_range(3) : 1);
		end
		return pt;
	endfunction

	function automatic particle_t fill(input longint p, input longint v, input longint e,
			input longint b);
		particle_t pt;
		for (int d = 0; d < 3; d++) begin
			pt.p[d] = p[47:0];
			pt.v[d] = v[47:0];
			pt.e[d] = e[47:0];
			pt.b[d] = b[47:0];
		end
		return pt;
	endfunction

	task automatic test_corners;
		particle_t pt;
		send_particle(fill(0, 0, 0, 0));
		send_particle(fill(P_MAX, P_MAX, P_MAX, P_MAX));
		send_particle(fill(P_MIN, P_MIN, P_MIN, P_MIN));
		send_particle(fill(P_ONE, 2 * P_ONE, P_ONE, P_ONE));
		send_particle(fill(-P_ONE, P_ONE / 4, P_ONE, 0));
		send_particle(fill(P_ONE, 0, P_ONE / 2, P_ONE));
		pt = fill(P_ONE, P_ONE / 8, P_ONE, 0);
		pt.b[0] = P_ONE[47:0];
		pt.v[1] = 48'(-P_ONE / 3);
		send_particle(pt);
		pt = fill(P_MIN, P_MAX, P_MIN, P_MAX);
		pt.b[2] = P_MIN[47:0];
		send_particle(pt);
		drain();
	endtask

	task automatic test_random(input int n, input int wild_pct);
		for (int i = 0; i < n; i++)
			send_particle(rand_particle($urandom_range(99) < wild_pct));
		drain();
	endtask

	task automatic test_backpressure;
		hold_req = 1;
		for (int i = 0; i < 5; i++) send_particle(rand_particle(0));
		drain();
	endtask

	initial begin
		longint phys [rbp_pkg::NUM_CFG];
		longint top [rbp_pkg::NUM_CFG];
		longint none [rbp_pkg::NUM_CFG];
		longint rnd [rbp_pkg::NUM_CFG];
		errors = 0;
		cycles = 0;
		calm = 0;
		hold_req = 0;
		run_max = 1;
		for (int i = 0; i < rbp_pkg::NUM_CFG; i++) cfg_regs[i] = 0;
		cfg_regs[rbp_pkg::CFG_IC2] = P_ONE;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		for (int d = 0; d < 3; d++) begin
			pin[d] = '0;
			vin[d] = '0;
			ein[d] = '0;
			bfld[d] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		phys = '{P_ONE / 20, P_ONE / 10, P_ONE, P_ONE / 2, P_ONE / 3, P_ONE / 4, P_ONE};
		top = '{P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX};
		none = '{0, 0, 0, 0, 0, 0, 0};

		test_corners();
		write_config(phys);
		test_corners();
		test_backpressure();
		calm = 1;
		test_random(150, 15);
		calm = 0;
		write_config(top);
		test_random(40, 40);
		write_config(none);
		test_random(40, 40);
		for (int i = 0; i < rbp_pkg::NUM_CFG; i++) rnd[i] = {$urandom, $urandom} & MASK47;
		write_config(rnd);
		test_random(40, 60);
		for (int i = 0; i < rbp_pkg::NUM_CFG; i++) rnd[i] = longint'($urandom_range(1 << 25));
		write_config(rnd);
		test_random(190, 15);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rbp_pkg.sv
rtl/core/rbp_rf.sv
rtl/core/rbp_alu.sv
rtl/core/relativistic_boris_particle_push_core.sv
dv/relativistic_boris_particle_push_core_tb.sv
